// File: src/pagc_pkg.sv
// Shared types and constants for the pin-addressed GPIO controller.
// Used by pagc_ctrl, pagc_dp and pin_addressed_gpio_controller_top.
package pagc_pkg;

    localparam int unsigned NUM_PORTS   = 3;
    localparam int unsigned PORT_W      = 8;
    localparam int unsigned IN_DATA_W   = 64;
    localparam int unsigned OUT_DATA_W  = 56;

    localparam logic [PORT_W-1:0] SHORT_MASK = 8'h3f;
    localparam logic [PORT_W-1:0] FULL_MASK  = 8'hff;
    localparam logic [PORT_W-1:0] BIT_ONE    = 8'h01;

    // port codes
    localparam logic [1:0] PORT_B = 2'd0;
    localparam logic [1:0] PORT_C = 2'd1;
    localparam logic [1:0] PORT_D = 2'd2;

    typedef enum logic [2:0] {
        FN_SET_INPUT  = 3'd0,
        FN_SET_OUTPUT = 3'd1,
        FN_READ_PIN   = 3'd2,
        FN_WRITE_PIN  = 3'd3,
        FN_TOGGLE     = 3'd4,
        FN_READ_PORT  = 3'd5,
        FN_WRITE_PORT = 3'd6
    } t_func;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // latch the incoming word
        logic commit;   // execute the held operation
    } t_cmd;

endpackage

// File: src/pagc_ctrl.sv
// Controller state machine: input handshake, execute step, result handshake.
// Depends on pagc_pkg (t_cmd).
module pagc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output pagc_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_SEND = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = (r_state == S_SEND);
    assign o_cmd.capture = i_in_valid && (r_state == S_IDLE);
    assign o_cmd.commit  = (r_state == S_EXEC);

endmodule

// File: src/pagc_dp.sv
// Datapath: held input word, direction registers, output latches, result flag/data.
// Depends on pagc_pkg (t_func, t_cmd, masks, port codes).
module pagc_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pagc_pkg::t_cmd                    i_cmd,
    input  logic [2:0]                        i_func,
    input  logic [pagc_pkg::IN_DATA_W-1:0]    i_data,
    output logic                              o_error,
    output logic [pagc_pkg::OUT_DATA_W-1:0]   o_data
);

    logic [2:0]                     r_func;
    logic [pagc_pkg::IN_DATA_W-1:0] r_data;

    logic [pagc_pkg::PORT_W-1:0] r_dir [pagc_pkg::NUM_PORTS];
    logic [pagc_pkg::PORT_W-1:0] r_lat [pagc_pkg::NUM_PORTS];
    logic                        r_err;
    logic [pagc_pkg::PORT_W-1:0] r_rd;

    logic [pagc_pkg::PORT_W-1:0] n_dir_sel;
    logic [pagc_pkg::PORT_W-1:0] n_lat_sel;
    logic                        n_err;
    logic [pagc_pkg::PORT_W-1:0] n_rd;

    // unpacked fields of the held word
    logic [7:0] pin_number;
    logic       pull_up;
    logic [7:0] pin_value;
    logic [7:0] port_select;
    logic [7:0] port_values;
    logic [7:0] levels_b;
    logic [7:0] levels_c;
    logic [7:0] levels_d;

    assign pin_number  = r_data[7:0];
    assign pull_up     = r_data[8];
    assign pin_value   = r_data[16:9];
    assign port_select = r_data[24:17];
    assign port_values = r_data[32:25];
    assign levels_b    = r_data[40:33];
    assign levels_c    = r_data[48:41];
    assign levels_d    = r_data[56:49];

    logic                        pin_ok;
    logic [1:0]                  pin_sel;
    logic [1:0]                  port;
    logic [pagc_pkg::PORT_W-1:0] onebit;
    logic [pagc_pkg::PORT_W-1:0] mask;
    logic [pagc_pkg::PORT_W-1:0] levels;
    logic [pagc_pkg::PORT_W-1:0] cur_dir;
    logic [pagc_pkg::PORT_W-1:0] cur_lat;
    pagc_pkg::t_func             func;

    assign func   = pagc_pkg::t_func'(r_func);
    assign onebit = pagc_pkg::BIT_ONE << pin_number[2:0];

    always_comb begin
        pin_ok  = 1'b1;
        pin_sel = pagc_pkg::PORT_B;
        if (pin_number inside {[8'd0:8'd5]}) begin
            pin_sel = pagc_pkg::PORT_B;
        end else if (pin_number inside {[8'd8:8'd13]}) begin
            pin_sel = pagc_pkg::PORT_C;
        end else if (pin_number inside {[8'd16:8'd23]}) begin
            pin_sel = pagc_pkg::PORT_D;
        end else begin
            pin_ok = 1'b0;
        end
    end

    // pin ops address by pin number, port ops by port code
    assign port = (func inside {pagc_pkg::FN_READ_PORT, pagc_pkg::FN_WRITE_PORT})
                  ? port_select[1:0] : pin_sel;

    always_comb begin
        case (port)
            pagc_pkg::PORT_B: levels = levels_b;
            pagc_pkg::PORT_C: levels = levels_c;
            default:          levels = levels_d;
        endcase
    end

    assign mask    = (port == pagc_pkg::PORT_D) ? pagc_pkg::FULL_MASK : pagc_pkg::SHORT_MASK;
    assign cur_dir = r_dir[port];
    assign cur_lat = r_lat[port];

    always_comb begin
        n_err     = 1'b0;
        n_rd      = '0;
        n_dir_sel = cur_dir;
        n_lat_sel = cur_lat;
        case (func)
            pagc_pkg::FN_SET_INPUT: begin
                if (!pin_ok) begin
                    n_err = 1'b1;
                end else begin
                    n_dir_sel = cur_dir & ~onebit;
                    if (pull_up) n_lat_sel = cur_lat | onebit;
                end
            end
            pagc_pkg::FN_SET_OUTPUT: begin
                if (!pin_ok) n_err = 1'b1;
                else         n_dir_sel = cur_dir | onebit;
            end
            pagc_pkg::FN_READ_PIN: begin
                if (!pin_ok) n_err = 1'b1;
                else         n_rd = {7'd0, levels[pin_number[2:0]]};
            end
            pagc_pkg::FN_WRITE_PIN: begin
                if (!pin_ok || pin_value[7:1] != 7'd0) begin
                    n_err = 1'b1;
                end else if (pin_value[0]) begin
                    n_lat_sel = cur_lat | onebit;
                end else begin
                    n_lat_sel = cur_lat & ~onebit;
                end
            end
            pagc_pkg::FN_TOGGLE: begin
                if (!pin_ok) n_err = 1'b1;
                else         n_lat_sel = cur_lat ^ onebit;
            end
            pagc_pkg::FN_READ_PORT: begin
                if (port_select > 8'd2) n_err = 1'b1;
                else                    n_rd = levels & mask;
            end
            pagc_pkg::FN_WRITE_PORT: begin
                if (port_select > 8'd2) n_err = 1'b1;
                else                    n_lat_sel = (cur_lat & ~mask) | (port_values & mask);
            end
            default: begin
                n_err = 1'b1;
            end
        endcase
    end

    // held input word: payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_data <= i_data;
        end
        if (i_cmd.commit) begin
            r_rd <= n_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pagc_pkg::NUM_PORTS; i++) begin
                r_dir[i] <= '0;
                r_lat[i] <= '0;
            end
            r_err <= 1'b0;
        end else if (i_cmd.commit) begin
            r_err <= n_err;
            if (!n_err) begin
                r_dir[port] <= n_dir_sel;
                r_lat[port] <= n_lat_sel;
            end
        end
    end

    assign o_error = r_err;
    assign o_data  = {r_lat[2], r_dir[2], r_lat[1], r_dir[1], r_lat[0], r_dir[0], r_rd};

endmodule

// File: src/pin_addressed_gpio_controller_top.sv
// GPIO controller with three ports B, C, D: each item carries one pin or port
// operation and returns one word with the error flag, read data and all six
// registers after the operation. Each item steps through accept, execute and
// present result, the last held through any output stall; the controller state machine
// handles one item at a time. Reset sets all pins to inputs with cleared latches.
// Depends on pagc_pkg, pagc_ctrl and pagc_dp.
module pin_addressed_gpio_controller_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] pin_number, [8] pull_up, [16:9] pin_value, [24:17] port_select,
    // [32:25] port_values, [40:33] levels_b, [48:41] levels_c, [56:49] levels_d
    input  logic [pagc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [2:0] func
    input  logic [2:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] read_data, [15:8] dir_b, [23:16] drive_b, [31:24] dir_c,
    // [39:32] drive_c, [47:40] dir_d, [55:48] drive_d
    output logic [pagc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // [0] error
    output logic                              m_axis_tuser
);

    pagc_pkg::t_cmd cmd;

    pagc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    pagc_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_func  (s_axis_tuser),
        .i_data  (s_axis_tdata),
        .o_error (m_axis_tuser),
        .o_data  (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // an error word never carries read data
    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
        else $error("error word with nonzero read data");

    // ports B and C have no bits above 5
    a_short_ports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tdata[15:14] == 2'd0 && m_axis_tdata[23:22] == 2'd0 &&
        m_axis_tdata[31:30] == 2'd0 && m_axis_tdata[39:38] == 2'd0)
        else $error("upper bits of port B or C set");

    // one item in flight: never accepting while a result is shown
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    // registers hold while a result waits
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata[55:8]))
        else $error("registers changed during output stall");
`endif

endmodule
